@@ design/ahci_command_descriptor_builder_assert.svh @@
// Assertion macros used by the checker file of the descriptor builder.
`ifndef AHCI_COMMAND_DESCRIPTOR_BUILDER_ASSERT_SVH
`define AHCI_COMMAND_DESCRIPTOR_BUILDER_ASSERT_SVH
// Same-cycle implication, disabled while reset is low.
`define ACDB_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define ACDB_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/acdb_pkg.sv @@
// Types and constants shared by the AHCI command descriptor builder files.
`default_nettype none
package acdb_pkg;

  // Default geometry
  localparam int ENTRY_SLOTS_DEF  = 8;
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int TABLE_STRIDE_DEF = 384;
  localparam int SLOT_COUNT_DEF   = 32;

  // Largest byte count of one PRDT entry
  localparam int MAX_ENTRY_BYTES = 4 * 1024 * 1024;
  // Width that holds any entry byte count up to and including the maximum
  localparam int BYTES_W = 23;
  // Sector count width
  localparam int CNT_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // ATA opcodes
  localparam logic [7:0] OP_READ  = 8'h25;
  localparam logic [7:0] OP_WRITE = 8'h35;

  // Record status codes
  localparam logic [2:0] ST_ENTRY  = 3'd0;
  localparam logic [2:0] ST_CMD    = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_NOSLOT = 3'd3;
  localparam logic [2:0] ST_SIZE   = 3'd4;

  // One transfer request
  typedef struct packed {
    logic [47:0] lba;
    logic [15:0] sectors;
    logic [63:0] buffer_addr;
    logic        is_write;
    logic [31:0] busy_slots;
  } req_t;

  // One emitted record
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [2:0]  entry_index;
    logic [63:0] data_addr;
    logic [21:0] byte_count_m1;
    logic [63:0] table_addr;
    logic [3:0]  entry_total;
    logic        write_flag;
    logic [7:0]  command_code;
    logic [47:0] fis_lba;
    logic [15:0] fis_count;
    logic        last;
  } rec_t;

endpackage
`default_nettype wire

@@ design/ahci_command_descriptor_builder.sv @@
// AHCI command descriptor builder: PRDT entry and command records per request.
`default_nettype none
// Usage
//   Request channel: drive in_item and raise start; the word is taken at the
//   edge where start is high and busy is low. busy stays high until the last
//   record of that request is on the output.
//   Result channel: each record shows on out_item for one cycle with out_valid
//   high. The receiver cannot stall; every record must be taken when shown.
//   Configuration: APB-style port, table_base at byte address 0 (64-bit data,
//   paddr[3] selects the register). Write only while busy is low.
// Timing
//   A request first forms the entry quotient with a reciprocal multiply in
//   S_DIV, then the check state S_CHECK finds the remainder and the table
//   address. An error record is formed in S_CHECK and registered onto the
//   output. Otherwise the records come from S_EMIT, S_REM and S_CMD in that
//   order, one record following per cycle, up to ENTRY_SLOTS + 1 records;
//   the next request is not taken before the previous one has shown its last
//   record. The 64-bit table and data address sums share one adder. busy
//   falls in the cycle the last record is shown.
// Reset
//   rst_n sampled low at a rising clock edge returns to idle, drops any
//   request in progress and clears table_base to zero.
module ahci_command_descriptor_builder #(
  parameter int ENTRY_SLOTS  = acdb_pkg::ENTRY_SLOTS_DEF,
  parameter int SECTOR_BYTES = acdb_pkg::SECTOR_BYTES_DEF,
  parameter int TABLE_STRIDE = acdb_pkg::TABLE_STRIDE_DEF,
  parameter int SLOT_COUNT   = acdb_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  acdb_pkg::req_t                    in_item,
  output logic                              out_valid,
  output acdb_pkg::rec_t                    out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acdb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [acdb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [acdb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import acdb_pkg::*;

  localparam int DIVISOR  = ENTRY_SLOTS - 1;
  localparam int REM_W    = $clog2(ENTRY_SLOTS);
  localparam int IDX_W    = $clog2(ENTRY_SLOTS + 1);
  localparam int MAX_PER  = MAX_ENTRY_BYTES / SECTOR_BYTES;
  localparam int TOFF_W   = 5 + $clog2(TABLE_STRIDE + 1);
  localparam int RECIP_SH = CNT_W + REM_W;
  localparam int PROD_W   = RECIP_SH + CNT_W;
  localparam int RECIP    = ((1 << RECIP_SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [CNT_W-1:0]    DIV_K     = CNT_W'(DIVISOR);
  localparam logic [PROD_W-1:0]   RECIP_K   = PROD_W'(RECIP);
  localparam logic [IDX_W-1:0]    LAST_EQ   = IDX_W'(ENTRY_SLOTS - 2);
  localparam logic [BYTES_W-1:0]  SECT_B    = BYTES_W'(SECTOR_BYTES);
  localparam logic [TOFF_W-1:0]   STRIDE_B  = TOFF_W'(TABLE_STRIDE);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_CHECK = 6'b000100,
    S_EMIT  = 6'b001000,
    S_REM   = 6'b010000,
    S_CMD   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [63:0]         table_base_r, table_base_nxt;
  req_t                req_r, req_nxt;
  logic [CNT_W-1:0]    quo_r, quo_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [4:0]          slot_r, slot_nxt;
  logic                slot_ok_r, slot_ok_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [63:0]         addr_r, addr_nxt;
  logic [63:0]         taddr_r, taddr_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  rec_t                rec_r, rec_nxt;

  logic [4:0]          slot_sel;
  logic                slot_hit;
  logic [PROD_W-1:0]   recip_prod;
  logic [CNT_W-1:0]    quo_calc;
  logic [CNT_W-1:0]    rem_calc;
  logic [63:0]         add_a, add_b, add_sum;
  logic [TOFF_W-1:0]   toff;
  logic [BYTES_W-1:0]  per_bytes, rem_bytes;
  logic [BYTES_W-1:0]  per_bm1, rem_bm1;
  logic [31:0]         idx_ext;
  logic                cfg_wr;

  // Find the lowest free slot of the incoming request
  always_comb begin
    slot_hit = 1'b0;
    slot_sel = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_item.busy_slots[i]) begin
        slot_hit = 1'b1;
        slot_sel = 5'(i);
      end
    end
  end

  // Divide by a rounded-up reciprocal; exact over the whole count range
  assign recip_prod = PROD_W'(req_r.sectors) * RECIP_K;
  assign quo_calc   = recip_prod[RECIP_SH +: CNT_W];
  // Remainder from the registered quotient
  assign rem_calc   = req_r.sectors - quo_r * DIV_K;

  // Shared 64-bit adder: table address in the check cycle, data address later
  assign toff  = TOFF_W'(slot_r) * STRIDE_B;
  assign add_a = (state_r == S_CHECK) ? table_base_r : addr_r;
  assign add_b = (state_r == S_CHECK) ? 64'(toff) : 64'(bytes_r);
  assign add_sum = add_a + add_b;

  // Entry byte counts
  assign per_bytes = BYTES_W'(quo_r) * SECT_B;
  assign rem_bytes = BYTES_W'(rem_r) * SECT_B;
  assign per_bm1   = bytes_r - BYTES_W'(1);
  assign rem_bm1   = rem_bytes - BYTES_W'(1);
  assign idx_ext   = 32'(idx_r);

  assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    table_base_nxt = table_base_r;
    req_nxt        = req_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    slot_nxt       = slot_r;
    slot_ok_nxt    = slot_ok_r;
    bytes_nxt      = bytes_r;
    addr_nxt       = addr_r;
    taddr_nxt      = taddr_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    rec_nxt        = rec_r;

    if (cfg_wr) begin
      table_base_nxt = pwdata;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_item;
          slot_nxt    = slot_sel;
          slot_ok_nxt = slot_hit;
          idx_nxt     = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt   = quo_calc;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        rec_nxt      = '0;
        rec_nxt.last = 1'b1;
        if (req_r.sectors == '0) begin
          rec_nxt.status = ST_ZERO;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!slot_ok_r) begin
          rec_nxt.status = ST_NOSLOT;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (32'(quo_r) > 32'(MAX_PER)) begin
          rec_nxt.status = ST_SIZE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          taddr_nxt = add_sum;
          bytes_nxt = per_bytes;
          addr_nxt  = req_r.buffer_addr;
          rem_nxt   = rem_calc[REM_W-1:0];
          if (quo_r != '0) begin
            state_nxt = S_EMIT;
          end else if (rem_calc != '0) begin
            state_nxt = S_REM;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      S_EMIT: begin
        rec_nxt               = '0;
        rec_nxt.status        = ST_ENTRY;
        rec_nxt.slot          = slot_r;
        rec_nxt.entry_index   = idx_ext[2:0];
        rec_nxt.data_addr     = addr_r;
        rec_nxt.byte_count_m1 = per_bm1[21:0];
        rec_nxt.table_addr    = taddr_r;
        out_valid_nxt         = 1'b1;
        addr_nxt              = add_sum;
        idx_nxt               = idx_r + IDX_W'(1);
        if (idx_r == LAST_EQ) begin
          state_nxt = (rem_r != '0) ? S_REM : S_CMD;
        end
      end
      S_REM: begin
        rec_nxt               = '0;
        rec_nxt.status        = ST_ENTRY;
        rec_nxt.slot          = slot_r;
        rec_nxt.entry_index   = idx_ext[2:0];
        rec_nxt.data_addr     = addr_r;
        rec_nxt.byte_count_m1 = rem_bm1[21:0];
        rec_nxt.table_addr    = taddr_r;
        out_valid_nxt         = 1'b1;
        idx_nxt               = idx_r + IDX_W'(1);
        state_nxt             = S_CMD;
      end
      S_CMD: begin
        rec_nxt              = '0;
        rec_nxt.status       = ST_CMD;
        rec_nxt.slot         = slot_r;
        rec_nxt.table_addr   = taddr_r;
        rec_nxt.entry_total  = idx_ext[3:0];
        rec_nxt.write_flag   = req_r.is_write;
        rec_nxt.command_code = req_r.is_write ? OP_WRITE : OP_READ;
        rec_nxt.fis_lba      = req_r.lba;
        rec_nxt.fis_count    = req_r.sectors;
        rec_nxt.last         = 1'b1;
        out_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      table_base_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      table_base_r <= table_base_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    slot_r    <= slot_nxt;
    slot_ok_r <= slot_ok_nxt;
    bytes_r   <= bytes_nxt;
    addr_r    <= addr_nxt;
    taddr_r   <= taddr_nxt;
    idx_r     <= idx_nxt;
    rec_r     <= rec_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = rec_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[3] ? '0 : table_base_r;

endmodule
`default_nettype wire

@@ design/acdb_checker.sv @@
// Port-level checker for the descriptor builder and its bind statement.
`default_nettype none
`include "ahci_command_descriptor_builder_assert.svh"
module acdb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input acdb_pkg::rec_t out_item
);
  import acdb_pkg::*;

  // An accepted request keeps the block busy and shows no record next cycle
  `ACDB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid, "accept did not raise busy")
  // The final record releases the block
  `ACDB_ASSERT_SAME(a_last_idle, clk, rst_n, out_valid && out_item.last, !busy, "busy after last record")
  // Records before the last come while busy
  `ACDB_ASSERT_SAME(a_mid_busy, clk, rst_n, out_valid && !out_item.last, busy, "record outside a request")
  // Error records stand alone with cleared fields
  `ACDB_ASSERT_SAME(a_err_alone, clk, rst_n, out_valid && (out_item.status == ST_ZERO || out_item.status == ST_NOSLOT || out_item.status == ST_SIZE), out_item.last && out_item.slot == '0 && out_item.table_addr == '0, "malformed error record")
  // An entry record is always followed at once by another record
  `ACDB_ASSERT_NEXT(a_entry_next, clk, rst_n, out_valid && out_item.status == ST_ENTRY, out_valid, "gap after entry record")

endmodule

bind ahci_command_descriptor_builder acdb_checker u_acdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
